// File: hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int DEF_SCREEN_COLUMNS = 80;
    localparam int DEF_SCREEN_ROWS    = 25;

    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int OP_W   = 2;

    localparam logic [ATTR_W-1:0] ATTR_AT_RESET   = 8'd12;
    localparam logic [CHAR_W-1:0] BLANK_CHAR      = 8'h20;
    localparam logic [CHAR_W-1:0] LINE_FEED       = 8'd10;
    localparam logic [CHAR_W-1:0] CARRIAGE_RETURN = 8'd13;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;       // latch the input beat
        logic sweep_start;  // arm a clear sweep, home the cursor
        logic sweep_step;   // write one cleared cell
        logic put;          // write the character, move the cursor
        logic read;         // issue the cell read
        logic scroll_step;  // read one source cell, write the pending one
        logic scroll_flush; // write the last pending cell
        logic blank_step;   // blank one cell of the bottom row
        logic out_load;     // load the result register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic sweep_last;
        logic put_scroll;
        logic src_last;
        logic blank_last;
    } t_sts;

endpackage

// File: hw/rtl/tcw_ctrl.sv
// Sequencing state machine of the text console writer.
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [tcw_pkg::OP_W-1:0] i_operation,
    input  logic                     i_out_stall,
    input  tcw_pkg::t_sts            i_sts,
    output tcw_pkg::t_cmd            o_cmd,
    output logic                     o_in_stall,
    output logic                     o_out_valid
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_PUT,
        S_READ,
        S_SCROLL,
        S_FLUSH,
        S_BLANK,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_operation)
                        tcw_pkg::OP_PUT: begin
                            n_state = S_PUT;
                        end
                        tcw_pkg::OP_CLEAR: begin
                            o_cmd.sweep_start = 1'b1;
                            n_state = S_CLEAR;
                        end
                        tcw_pkg::OP_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state = i_sts.put_scroll ? S_SCROLL : S_DONE;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state = S_DONE;
            end
            S_SCROLL: begin
                o_cmd.scroll_step = 1'b1;
                if (i_sts.src_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.scroll_flush = 1'b1;
                n_state = S_BLANK;
            end
            S_BLANK: begin
                o_cmd.blank_step = 1'b1;
                if (i_sts.blank_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/tcw_datapath.sv
// Screen store, cursor, sweep counters and result register of the console writer.
`timescale 1ns / 1ps

module tcw_datapath #(
    parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS,
    parameter int COL_W          = $clog2(SCREEN_COLUMNS),
    parameter int ROW_W          = $clog2(SCREEN_ROWS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tcw_pkg::t_cmd                i_cmd,
    output tcw_pkg::t_sts                o_sts,
    input  logic                         i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]   i_cfg_wdata,
    input  logic [tcw_pkg::OP_W-1:0]     i_operation,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_character,
    input  logic [ROW_W-1:0]             i_read_row,
    input  logic [COL_W-1:0]             i_read_col,
    output logic [COL_W-1:0]             o_cursor_col,
    output logic [ROW_W-1:0]             o_cursor_row,
    output logic [tcw_pkg::CHAR_W-1:0]   o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]   o_cell_attr,
    output logic                         o_scrolled
);

    localparam int CELLS  = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int PROD_W = ROW_W + COL_W + 1;

    localparam logic [ADDR_W-1:0] ADDR_LAST   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ADDR_COLS   = ADDR_W'(SCREEN_COLUMNS);
    localparam logic [ADDR_W-1:0] ADDR_BOTTOM = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
    localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [ROW_W:0]    ROWS_EXT    = (ROW_W + 1)'(SCREEN_ROWS);
    localparam logic [COL_W:0]    COLS_EXT    = (COL_W + 1)'(SCREEN_COLUMNS);

    logic [tcw_pkg::CELL_W-1:0] r_screen [CELLS];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    logic [tcw_pkg::ATTR_W-1:0] r_attr;
    logic [COL_W-1:0]           r_cur_col;
    logic [ROW_W-1:0]           r_cur_row;
    logic [ADDR_W-1:0]          r_cur_addr;
    logic [ADDR_W-1:0]          r_sw_addr;
    logic [COL_W-1:0]           r_sw_col;
    logic [tcw_pkg::ATTR_W-1:0] r_sw_attr;
    logic [tcw_pkg::ATTR_W-1:0] r_row_attr;
    logic [ADDR_W-1:0]          r_src;
    logic [ADDR_W-1:0]          r_dst;
    logic                       r_pend;
    logic                       r_scrolled;

    logic [tcw_pkg::CHAR_W-1:0] r_ch;
    logic [ADDR_W-1:0]          r_rd_addr;
    logic                       r_rd_ok;
    logic                       r_is_read;

    logic [COL_W-1:0]           r_o_col;
    logic [ROW_W-1:0]           r_o_row;
    logic [tcw_pkg::CHAR_W-1:0] r_o_char;
    logic [tcw_pkg::ATTR_W-1:0] r_o_attr;
    logic                       r_o_scr;

    logic                       newline, end_col, last_row, wrap;
    logic [PROD_W-1:0]          rd_prod;
    logic                       rd_in_range;
    logic                       mem_we, mem_re;
    logic [ADDR_W-1:0]          mem_waddr, mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic [tcw_pkg::ATTR_W-1:0] next_row_attr;

    assign newline  = (r_ch == tcw_pkg::LINE_FEED) || (r_ch == tcw_pkg::CARRIAGE_RETURN);
    assign end_col  = (r_cur_col == COL_LAST);
    assign last_row = (r_cur_row == ROW_LAST);
    assign wrap     = newline || end_col;

    assign rd_prod = PROD_W'(i_read_row) * PROD_W'(SCREEN_COLUMNS) + PROD_W'(i_read_col);
    assign rd_in_range = ({1'b0, i_read_row} < ROWS_EXT) && ({1'b0, i_read_col} < COLS_EXT);

    assign next_row_attr = r_row_attr + 8'd1;

    assign o_sts.sweep_last = (r_sw_addr == ADDR_LAST);
    assign o_sts.put_scroll = wrap && last_row;
    assign o_sts.src_last   = (r_src == ADDR_LAST);
    assign o_sts.blank_last = (r_dst == ADDR_LAST);

    // one write port shared by sweep, put, scroll copy and bottom-row blanking
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_dst;
        mem_wdata = r_rdata;
        if (i_cmd.sweep_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_sw_addr;
            mem_wdata = {tcw_pkg::BLANK_CHAR, r_sw_attr};
        end else if (i_cmd.put) begin
            mem_we    = !newline;
            mem_waddr = r_cur_addr;
            mem_wdata = {r_ch, r_attr};
        end else if (i_cmd.scroll_step || i_cmd.scroll_flush) begin
            mem_we    = r_pend;
        end else if (i_cmd.blank_step) begin
            mem_we    = 1'b1;
            mem_wdata = {tcw_pkg::BLANK_CHAR, r_attr};
        end
    end

    assign mem_re    = i_cmd.scroll_step || (i_cmd.read && r_rd_ok);
    assign mem_raddr = i_cmd.scroll_step ? r_src : r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_screen[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr     <= tcw_pkg::ATTR_AT_RESET;
            r_cur_col  <= '0;
            r_cur_row  <= '0;
            r_cur_addr <= '0;
            r_sw_addr  <= '0;
            r_sw_col   <= '0;
            r_sw_attr  <= tcw_pkg::ATTR_AT_RESET;
            r_row_attr <= tcw_pkg::ATTR_AT_RESET;
            r_src      <= ADDR_COLS;
            r_dst      <= '0;
            r_pend     <= 1'b0;
            r_scrolled <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_scrolled <= 1'b0;
            end
            if (i_cmd.sweep_start) begin
                r_sw_addr  <= '0;
                r_sw_col   <= '0;
                r_sw_attr  <= r_attr;
                r_row_attr <= r_attr;
                r_cur_col  <= '0;
                r_cur_row  <= '0;
                r_cur_addr <= '0;
            end
            if (i_cmd.sweep_step) begin
                r_sw_addr <= r_sw_addr + 1'b1;
                if (r_sw_col == COL_LAST) begin
                    r_sw_col   <= '0;
                    r_row_attr <= next_row_attr;
                    r_sw_attr  <= next_row_attr;
                end else begin
                    r_sw_col  <= r_sw_col + 1'b1;
                    r_sw_attr <= r_sw_attr + 8'd1;
                end
            end
            if (i_cmd.put) begin
                // arm the scroll copy: row one moves onto row zero
                r_src      <= ADDR_COLS;
                r_dst      <= '0;
                r_pend     <= 1'b0;
                r_scrolled <= wrap && last_row;
                if (!wrap) begin
                    r_cur_col  <= r_cur_col + 1'b1;
                    r_cur_addr <= r_cur_addr + 1'b1;
                end else if (!last_row) begin
                    r_cur_col  <= '0;
                    r_cur_row  <= r_cur_row + 1'b1;
                    r_cur_addr <= r_cur_addr + ADDR_COLS - ADDR_W'(r_cur_col);
                end else begin
                    r_cur_col  <= '0;
                    r_cur_row  <= ROW_LAST;
                    r_cur_addr <= ADDR_BOTTOM;
                end
            end
            if (i_cmd.scroll_step) begin
                r_src  <= r_src + 1'b1;
                r_pend <= 1'b1;
            end
            if ((i_cmd.scroll_step || i_cmd.scroll_flush) && r_pend) begin
                r_dst <= r_dst + 1'b1;
            end
            if (i_cmd.scroll_flush) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.blank_step) begin
                r_dst <= r_dst + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch      <= i_character;
            r_rd_addr <= rd_prod[ADDR_W-1:0];
            r_rd_ok   <= rd_in_range;
            r_is_read <= (i_operation == tcw_pkg::OP_READ) && rd_in_range;
        end
        if (i_cmd.out_load) begin
            r_o_col  <= r_cur_col;
            r_o_row  <= r_cur_row;
            r_o_char <= r_is_read ? r_rdata[tcw_pkg::CELL_W-1:tcw_pkg::ATTR_W] : '0;
            r_o_attr <= r_is_read ? r_rdata[tcw_pkg::ATTR_W-1:0] : '0;
            r_o_scr  <= r_scrolled;
        end
    end

    assign o_cursor_col = r_o_col;
    assign o_cursor_row = r_o_row;
    assign o_cell_char  = r_o_char;
    assign o_cell_attr  = r_o_attr;
    assign o_scrolled   = r_o_scr;

endmodule

// File: hw/rtl/text_console_writer.sv
// Top level of the text console writer: controller, datapath and checks.
`timescale 1ns / 1ps

// Text-mode console with a SCREEN_ROWS x SCREEN_COLUMNS cell store (character
// and attribute per cell) and a cursor. One item at a time: a put that stays
// on screen and a read each pass through their own state and the done state
// before the result register is loaded; a put that scrolls walks the store
// through its single read and write port; a clear writes every cell once.
// After reset the store is swept to the cleared pattern with o_in_stall held
// high; write the attribute register only while no item is in flight. The
// result register frees the input side, so the next beat can be taken while a
// result still waits for the consumer.
module text_console_writer #(
    parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS,
    parameter int COL_W          = $clog2(SCREEN_COLUMNS),
    parameter int ROW_W          = $clog2(SCREEN_ROWS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [tcw_pkg::OP_W-1:0]   i_operation,
    input  logic [tcw_pkg::CHAR_W-1:0] i_character,
    input  logic [ROW_W-1:0]           i_read_row,
    input  logic [COL_W-1:0]           i_read_col,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [COL_W-1:0]           o_cursor_col,
    output logic [ROW_W-1:0]           o_cursor_row,
    output logic [tcw_pkg::CHAR_W-1:0] o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0] o_cell_attr,
    output logic                       o_scrolled
);

    tcw_pkg::t_cmd cmd;
    tcw_pkg::t_sts sts;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    tcw_datapath #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .COL_W          (COL_W),
        .ROW_W          (ROW_W)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_operation  (i_operation),
        .i_character  (i_character),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_scrolled   (o_scrolled)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in flight");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scrolled |->
            (o_cursor_col == '0) && (o_cursor_row == ROW_W'(SCREEN_ROWS - 1)))
        else $error("scroll reported with cursor off the bottom row start");

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_cursor_col} < (COL_W + 1)'(SCREEN_COLUMNS)) &&
                        ({1'b0, o_cursor_row} < (ROW_W + 1)'(SCREEN_ROWS)))
        else $error("cursor off screen");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer: puts, scrolls, clears and cell reads.
module tb;
    import tcw_pkg::*;

    localparam int COLS           = DEF_SCREEN_COLUMNS;
    localparam int ROWS           = DEF_SCREEN_ROWS;
    localparam int COL_W          = $clog2(COLS);
    localparam int ROW_W          = $clog2(ROWS);
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PRINT_LIMIT    = 40;
    localparam int PHASE_BEATS    = 146;
    localparam int PHASE_COUNT    = 5;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] character;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } console_cmd_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic              scrolled;
    } console_view_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [ATTR_W-1:0] i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [OP_W-1:0]   i_operation;
    logic [CHAR_W-1:0] i_character;
    logic [ROW_W-1:0]  i_read_row;
    logic [COL_W-1:0]  i_read_col;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [COL_W-1:0]  o_cursor_col;
    logic [ROW_W-1:0]  o_cursor_row;
    logic [CHAR_W-1:0] o_cell_char;
    logic [ATTR_W-1:0] o_cell_attr;
    logic              o_scrolled;

    text_console_writer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_character  (i_character),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_scrolled   (o_scrolled)
    );

    // shadow copy of the screen, cursor and attribute register
    logic [CHAR_W-1:0] shadow_char [ROWS][COLS];
    logic [ATTR_W-1:0] shadow_attr [ROWS][COLS];
    logic [COL_W-1:0]  shadow_col;
    logic [ROW_W-1:0]  shadow_row;
    logic [ATTR_W-1:0] shadow_text_attr;

    console_cmd_t  pending_beats [$];
    console_view_t expected_views [$];

    int beats_queued = 0;
    int beats_taken  = 0;
    int results_seen = 0;
    int error_count  = 0;
    int idle_cycles  = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    bit in_beat_taken      = 1'b0;
    bit sender_gaps_on     = 1'b1;
    bit consumer_stalls_on = 1'b1;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("ERROR at %0t, result %0d, %s: got 0x%0h, expected 0x%0h",
                     $time, results_seen, field, got, want);
    endtask

    task automatic clear_shadow();
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                shadow_char[r][c] = BLANK_CHAR;
                shadow_attr[r][c] = ATTR_W'(shadow_text_attr + c + r);
            end
        end
        shadow_col = '0;
        shadow_row = '0;
    endtask

    task automatic advance_console(input console_cmd_t cmd, output console_view_t view);
        logic wrap;
        view = '0;
        wrap = 1'b0;
        case (cmd.operation)
            OP_PUT: begin
                // line feed and carriage return move the cursor but are never stored
                if (cmd.character != LINE_FEED && cmd.character != CARRIAGE_RETURN) begin
                    shadow_char[shadow_row][shadow_col] = cmd.character;
                    shadow_attr[shadow_row][shadow_col] = shadow_text_attr;
                    if (shadow_col == COL_W'(COLS - 1))
                        wrap = 1'b1;
                    else
                        shadow_col = shadow_col + 1'b1;
                end else begin
                    wrap = 1'b1;
                end
                if (wrap) begin
                    shadow_col = '0;
                    if (shadow_row == ROW_W'(ROWS - 1)) begin
                        // shift every row up, blank the bottom one
                        for (int r = 0; r < ROWS - 1; r++) begin
                            shadow_char[r] = shadow_char[r + 1];
                            shadow_attr[r] = shadow_attr[r + 1];
                        end
                        for (int c = 0; c < COLS; c++) begin
                            shadow_char[ROWS - 1][c] = BLANK_CHAR;
                            shadow_attr[ROWS - 1][c] = shadow_text_attr;
                        end
                        view.scrolled = 1'b1;
                    end else begin
                        shadow_row = shadow_row + 1'b1;
                    end
                end
            end
            OP_CLEAR: clear_shadow();
            OP_READ: begin
                if (int'(cmd.read_row) < ROWS && int'(cmd.read_col) < COLS) begin
                    view.cell_char = shadow_char[cmd.read_row][cmd.read_col];
                    view.cell_attr = shadow_attr[cmd.read_row][cmd.read_col];
                end
            end
            default: ;
        endcase
        view.cursor_col = shadow_col;
        view.cursor_row = shadow_row;
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    // sender: hold a beat until taken, then advance after an optional gap
    always @(negedge i_clk) begin
        console_cmd_t beat;
        if (i_rst_n && (in_beat_taken || !i_in_valid)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                beat = pending_beats.pop_front();
                i_operation <= beat.operation;
                i_character <= beat.character;
                i_read_row  <= beat.read_row;
                i_read_col  <= beat.read_col;
                i_in_valid  <= 1'b1;
                gap_left = sender_gaps_on ? pick_gap() : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // consumer back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n || !consumer_stalls_on) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        console_cmd_t  cmd;
        console_view_t want;
        in_beat_taken = 1'b0;
        if (i_rst_n) begin
            // check the result before predicting, so a result with nothing pending is caught
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_views.size() == 0) begin
                    report_mismatch("result with nothing expected", 0, 0);
                end else begin
                    want = expected_views.pop_front();
                    if (o_cursor_col !== want.cursor_col)
                        report_mismatch("cursor_col", 32'(o_cursor_col),
                                        32'(want.cursor_col));
                    if (o_cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", 32'(o_cursor_row),
                                        32'(want.cursor_row));
                    if (o_cell_char !== want.cell_char)
                        report_mismatch("cell_char", 32'(o_cell_char),
                                        32'(want.cell_char));
                    if (o_cell_attr !== want.cell_attr)
                        report_mismatch("cell_attr", 32'(o_cell_attr),
                                        32'(want.cell_attr));
                    if (o_scrolled !== want.scrolled)
                        report_mismatch("scrolled", 32'(o_scrolled),
                                        32'(want.scrolled));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                cmd.operation = i_operation;
                cmd.character = i_character;
                cmd.read_row  = i_read_row;
                cmd.read_col  = i_read_col;
                advance_console(cmd, want);
                expected_views.push_back(want);
                in_beat_taken = 1'b1;
                beats_taken++;
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic queue_beat(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        console_cmd_t beat;
        beat.operation = op;
        beat.character = ch;
        beat.read_row  = row;
        beat.read_col  = col;
        pending_beats.push_back(beat);
        beats_queued++;
    endtask

    task automatic queue_put(input logic [CHAR_W-1:0] ch);
        queue_beat(OP_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic queue_read(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        queue_beat(OP_READ, CHAR_W'($urandom), row, col);
    endtask

    task automatic wait_until_drained();
        do
            @(negedge i_clk);
        while (pending_beats.size() != 0 || beats_taken != beats_queued
               || expected_views.size() != 0);
    endtask

    task automatic set_text_attribute(input logic [ATTR_W-1:0] value);
        wait_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_text_attr = value;
    endtask

    task automatic run_random_phase(input int beat_count);
        int start;
        int roll;
        start = beats_queued;
        while (beats_queued - start < beat_count) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                // a line of text, usually closed by a newline; long ones wrap
                repeat ($urandom_range(1, 95)) queue_put(CHAR_W'($urandom));
                if ($urandom_range(0, 4) != 0)
                    queue_put($urandom_range(0, 1) ? LINE_FEED : CARRIAGE_RETURN);
            end else if (roll < 65) begin
                repeat ($urandom_range(1, 30))
                    queue_put($urandom_range(0, 1) ? LINE_FEED : CARRIAGE_RETURN);
            end else if (roll < 85) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 3) == 0)
                        queue_read(ROW_W'($urandom), COL_W'($urandom));
                    else if ($urandom_range(0, 1))
                        queue_read(ROW_W'($urandom_range(ROWS - 5, ROWS - 1)),
                                   COL_W'($urandom_range(0, COLS - 1)));
                    else
                        queue_read(ROW_W'($urandom_range(0, ROWS - 1)),
                                   COL_W'($urandom_range(0, COLS - 1)));
                end
            end else if (roll < 88) begin
                queue_beat(OP_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
            end else if (roll < 93) begin
                queue_beat(OP_UNUSED, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
            end else begin
                queue_beat(OP_W'($urandom_range(0, 3)), CHAR_W'($urandom),
                           ROW_W'($urandom), COL_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [ATTR_W-1:0] phase_attr [PHASE_COUNT];
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_operation = OP_PUT;
        i_character = '0;
        i_read_row  = '0;
        i_read_col  = '0;
        i_out_stall = 1'b0;
        shadow_text_attr = ATTR_AT_RESET;
        clear_shadow();
        phase_attr = '{8'h00, 8'hFF, ATTR_W'($urandom), 8'h80, ATTR_W'($urandom)};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // screen after reset, corners and reads off the screen
        queue_read('0, '0);
        queue_read(ROW_W'(ROWS - 1), COL_W'(COLS - 1));
        queue_read('1, '1);
        queue_read(ROW_W'(ROWS - 1), COL_W'(COLS));
        queue_read(ROW_W'(ROWS), '0);
        queue_beat(OP_UNUSED, '1, '1, '1);
        // extreme bytes and both newline codes
        queue_put(8'h00);
        queue_put(8'hFF);
        queue_put(8'h41);
        queue_put(LINE_FEED);
        queue_put(CARRIAGE_RETURN);
        queue_put(8'h7F);
        queue_read('0, '0);
        queue_read('0, 7'd1);
        queue_read('0, 7'd2);
        queue_read(5'd2, '0);
        queue_beat(OP_UNUSED, '0, '0, '0);
        queue_beat(OP_CLEAR, '1, '1, '1);
        queue_read('0, '0);
        queue_read(5'd12, 7'd40);
        queue_put(8'h55);
        queue_put(8'hAA);
        queue_read('0, 7'd1);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            set_text_attribute(phase_attr[phase]);
            // one phase runs with no idling on either side
            sender_gaps_on     = (phase != 1);
            consumer_stalls_on = (phase != 1);
            queue_beat(OP_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
            queue_read(ROW_W'(ROWS - 1), COL_W'(COLS - 1));
            run_random_phase(PHASE_BEATS);
        end

        wait_until_drained();
        repeat (40) @(posedge i_clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: text_console_writer.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_datapath.sv
hw/rtl/text_console_writer.sv
sim/tb.sv
